// ----- sv/spnf_pkg.sv -----
// Package for the staggered pixel neighbour finder.
// Holds widths, limits, config register indexes and the distance-unit request type.
// No dependencies.
`timescale 1ns / 1ps

package spnf_pkg;

  localparam int MAX_REACH = 3;
  localparam int COORD_W   = 16;
  localparam int REACH_W   = 2;
  localparam int DIM_W     = 15;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 15;

  // Candidate coordinates can step past the 16-bit range around the edges.
  localparam int EXT_W  = COORD_W + 1;
  localparam int DX_W   = EXT_W + 2;
  localparam int DY_W   = EXT_W + 1;
  localparam int RMAX   = 2 * MAX_REACH + 1;
  localparam int CNT_W  = $clog2(RMAX + 1);
  localparam int SDX_W  = $clog2(RMAX + 1) + 1;
  localparam int SDY_W  = $clog2(MAX_REACH + 1) + 1;
  localparam int SQ_W   = $clog2(RMAX * RMAX + 4 * MAX_REACH * MAX_REACH + 1);
  localparam int CMP_W  = (EXT_W > DIM_W) ? EXT_W : DIM_W;

  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_POS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS    = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS       = CFG_IDX_W'(2);

  localparam logic [DIM_W-1:0] COLUMNS_RST = DIM_W'(256);
  localparam logic [DIM_W-1:0] ROWS_RST    = DIM_W'(256);

  typedef struct packed {
    logic signed [EXT_W-1:0] ax;
    logic signed [EXT_W-1:0] ay;
    logic signed [EXT_W-1:0] bx;
    logic signed [EXT_W-1:0] by;
    logic [REACH_W-1:0]      reach;
    logic                    offset_pos;
  } dist_req_t;

endpackage

// ----- sv/spnf_if.sv -----
// Valid/ready channel interfaces for the neighbour finder: input items and results.
// Depends on spnf_pkg.
`timescale 1ns / 1ps

interface spnf_in_if;
  logic                                valid;
  logic                                ready;
  logic                                func;
  logic signed [spnf_pkg::COORD_W-1:0] center_x;
  logic signed [spnf_pkg::COORD_W-1:0] center_y;
  logic signed [spnf_pkg::COORD_W-1:0] other_x;
  logic signed [spnf_pkg::COORD_W-1:0] other_y;
  logic [spnf_pkg::REACH_W-1:0]        reach;

  modport source (output valid, func, center_x, center_y, other_x, other_y, reach,
                  input ready);
  modport sink (input valid, func, center_x, center_y, other_x, other_y, reach,
                output ready);
endinterface

interface spnf_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [spnf_pkg::COORD_W-1:0] neighbour_x;
  logic signed [spnf_pkg::COORD_W-1:0] neighbour_y;
  logic                                found;
  logic                                is_neighbour;
  logic                                last;

  modport source (output valid, neighbour_x, neighbour_y, found, is_neighbour, last,
                  input ready);
  modport sink (input valid, neighbour_x, neighbour_y, found, is_neighbour, last,
                output ready);
endinterface

// ----- sv/spnf_dist.sv -----
// Shared neighbour distance test: dx^2 + 4*dy^2 <= (2d+1)^2 on staggered rows.
// Depends on spnf_pkg.
`timescale 1ns / 1ps

module spnf_dist (
  input  spnf_pkg::dist_req_t req,
  output logic                near
);

  localparam logic signed [spnf_pkg::DX_W-1:0] DX_LIM = spnf_pkg::DX_W'(spnf_pkg::RMAX);
  localparam logic signed [spnf_pkg::DY_W-1:0] DY_LIM = spnf_pkg::DY_W'(spnf_pkg::MAX_REACH);

  logic signed [spnf_pkg::EXT_W:0]     diff_x;
  logic signed [2:0]                   half_a;
  logic signed [2:0]                   half_b;
  logic signed [spnf_pkg::DX_W-1:0]    dx;
  logic signed [spnf_pkg::DY_W-1:0]    dy;
  logic                                in_box;
  logic signed [spnf_pkg::SDX_W-1:0]   dx_s;
  logic signed [spnf_pkg::SDY_W-1:0]   dy_s;
  logic signed [2*spnf_pkg::SDX_W-1:0] dx_sq;
  logic signed [2*spnf_pkg::SDY_W-1:0] dy_sq;
  logic [spnf_pkg::SQ_W-1:0]           dist_sq;
  logic [spnf_pkg::REACH_W:0]          r;
  logic [spnf_pkg::SQ_W-1:0]           r_sq;

  // Odd rows sit half a pitch right or left at double resolution.
  assign half_a = req.ay[0] ? (req.offset_pos ? 3'sd1 : -3'sd1) : 3'sd0;
  assign half_b = req.by[0] ? (req.offset_pos ? 3'sd1 : -3'sd1) : 3'sd0;

  assign diff_x = (spnf_pkg::EXT_W+1)'(req.bx) - (spnf_pkg::EXT_W+1)'(req.ax);
  assign dx     = (spnf_pkg::DX_W'(diff_x) <<< 1) + spnf_pkg::DX_W'(half_b)
                  - spnf_pkg::DX_W'(half_a);
  assign dy     = spnf_pkg::DY_W'(req.by) - spnf_pkg::DY_W'(req.ay);

  // Anything beyond the largest radius can never pass; square only the small range.
  assign in_box = (dx <= DX_LIM) && (dx >= -DX_LIM) && (dy <= DY_LIM) && (dy >= -DY_LIM);
  assign dx_s   = dx[spnf_pkg::SDX_W-1:0];
  assign dy_s   = dy[spnf_pkg::SDY_W-1:0];
  assign dx_sq  = dx_s * dx_s;
  assign dy_sq  = dy_s * dy_s;
  assign dist_sq = spnf_pkg::SQ_W'(dx_sq) + (spnf_pkg::SQ_W'(dy_sq) << 2);

  assign r    = {req.reach, 1'b1};
  assign r_sq = spnf_pkg::SQ_W'(r) * spnf_pkg::SQ_W'(r);
  assign near = in_box && (dist_sq <= r_sq);

endmodule

// ----- sv/spnf_scan.sv -----
// Sequencer: walks the candidate box one pixel a cycle through the shared distance
// unit unless out_ch stalls it, holds one found pixel back to mark the last beat,
// drives the result register. Depends on spnf_pkg and spnf_if.
`timescale 1ns / 1ps

module spnf_scan (
  input  logic                     clk,
  input  logic                     rst_n,
  spnf_in_if.sink                  in_ch,
  spnf_out_if.source               out_ch,
  input  logic                     offset_pos,
  input  logic [spnf_pkg::DIM_W-1:0] columns,
  input  logic [spnf_pkg::DIM_W-1:0] rows,
  output spnf_pkg::dist_req_t      dist_req,
  input  logic                     near
);

  typedef enum logic [1:0] {S_IDLE, S_PAIR, S_SCAN, S_DONE} state_t;

  state_t                              state_r;
  logic signed [spnf_pkg::COORD_W-1:0] cx_r, cy_r, ox_r, oy_r;
  logic [spnf_pkg::REACH_W-1:0]        reach_r;
  logic [spnf_pkg::CNT_W-1:0]          col_r, row_r;
  logic                                pend_v_r;
  logic signed [spnf_pkg::COORD_W-1:0] pend_x_r, pend_y_r;
  logic                                out_valid_r;
  logic signed [spnf_pkg::COORD_W-1:0] out_x_r, out_y_r;
  logic                                out_found_r, out_isn_r, out_last_r;

  logic [spnf_pkg::REACH_W-1:0]        reach_in;
  logic [spnf_pkg::CNT_W-1:0]          span;
  logic signed [spnf_pkg::EXT_W-1:0]   nx, ny;
  logic                                in_matrix, hit, slot_free, last_cand;

  assign reach_in = (in_ch.reach > spnf_pkg::REACH_W'(spnf_pkg::MAX_REACH)) ?
                    spnf_pkg::REACH_W'(spnf_pkg::MAX_REACH) : in_ch.reach;
  assign span     = spnf_pkg::CNT_W'(reach_r) << 1;

  assign nx = spnf_pkg::EXT_W'(cx_r) - spnf_pkg::EXT_W'(reach_r) + spnf_pkg::EXT_W'(col_r);
  assign ny = spnf_pkg::EXT_W'(cy_r) - spnf_pkg::EXT_W'(reach_r) + spnf_pkg::EXT_W'(row_r);

  assign in_matrix = !nx[spnf_pkg::EXT_W-1] && !ny[spnf_pkg::EXT_W-1]
               && (spnf_pkg::CMP_W'($unsigned(nx)) < spnf_pkg::CMP_W'(columns))
               && (spnf_pkg::CMP_W'($unsigned(ny)) < spnf_pkg::CMP_W'(rows));
  assign hit       = near && in_matrix;
  assign last_cand = (col_r == span) && (row_r == span);
  assign slot_free = !out_valid_r || out_ch.ready;

  always_comb begin
    dist_req.ax         = spnf_pkg::EXT_W'(cx_r);
    dist_req.ay         = spnf_pkg::EXT_W'(cy_r);
    dist_req.reach      = reach_r;
    dist_req.offset_pos = offset_pos;
    if (state_r == S_PAIR) begin
      dist_req.bx = spnf_pkg::EXT_W'(ox_r);
      dist_req.by = spnf_pkg::EXT_W'(oy_r);
    end else begin
      dist_req.bx = nx;
      dist_req.by = ny;
    end
  end

  assign in_ch.ready         = (state_r == S_IDLE);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.neighbour_x  = out_x_r;
  assign out_ch.neighbour_y  = out_y_r;
  assign out_ch.found        = out_found_r;
  assign out_ch.is_neighbour = out_isn_r;
  assign out_ch.last         = out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      pend_v_r    <= 1'b0;
      col_r       <= '0;
      row_r       <= '0;
    end else begin
      if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            cx_r     <= in_ch.center_x;
            cy_r     <= in_ch.center_y;
            ox_r     <= in_ch.other_x;
            oy_r     <= in_ch.other_y;
            reach_r  <= reach_in;
            col_r    <= '0;
            row_r    <= '0;
            pend_v_r <= 1'b0;
            state_r  <= in_ch.func ? S_PAIR : S_SCAN;
          end
        end
        S_PAIR: begin
          if (slot_free) begin
            out_valid_r <= 1'b1;
            out_x_r     <= '0;
            out_y_r     <= '0;
            out_found_r <= 1'b0;
            out_isn_r   <= near;
            out_last_r  <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        S_SCAN: begin
          // A hit with a pixel already held must push the held one out first.
          if (!(hit && pend_v_r) || slot_free) begin
            if (hit) begin
              if (pend_v_r) begin
                out_valid_r <= 1'b1;
                out_x_r     <= pend_x_r;
                out_y_r     <= pend_y_r;
                out_found_r <= 1'b1;
                out_isn_r   <= 1'b0;
                out_last_r  <= 1'b0;
              end
              pend_v_r <= 1'b1;
              pend_x_r <= nx[spnf_pkg::COORD_W-1:0];
              pend_y_r <= ny[spnf_pkg::COORD_W-1:0];
            end
            if (last_cand) begin
              state_r <= S_DONE;
            end else if (col_r == span) begin
              col_r <= '0;
              row_r <= row_r + spnf_pkg::CNT_W'(1);
            end else begin
              col_r <= col_r + spnf_pkg::CNT_W'(1);
            end
          end
        end
        S_DONE: begin
          // Release the held pixel as the last beat, or an empty beat if none.
          if (slot_free) begin
            out_valid_r <= 1'b1;
            out_x_r     <= pend_v_r ? pend_x_r : '0;
            out_y_r     <= pend_v_r ? pend_y_r : '0;
            out_found_r <= pend_v_r;
            out_isn_r   <= 1'b0;
            out_last_r  <= 1'b1;
            pend_v_r    <= 1'b0;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- sv/staggered_pixel_neighbour_finder_core.sv -----
// Top level of the staggered pixel neighbour finder: config registers, sequencer
// and shared distance unit. Depends on spnf_pkg, spnf_if, spnf_dist, spnf_scan.
//
//   channel   dir   handshake           payload
//   in_ch     in    valid / ready       func, center_x/y, other_x/y, reach
//   out_ch    out   valid / ready       neighbour_x/y, found, is_neighbour, last
//   cfg_*     in    cfg_we (no wait)    cfg_idx, cfg_wdata
//
// A box scan accepts the item, then tests one candidate per cycle through the single
// distance unit while out_ch does not stall it, then sends the final beat. A pair
// test sends one result beat. in_ch.ready is high only while the sequencer is idle.
// A stalled out_ch holds the scan only when a second hit needs the result register.
// rst_n is synchronous; it clears control state and loads the config reset values.
`timescale 1ns / 1ps

module staggered_pixel_neighbour_finder_core (
  input  logic                           clk,
  input  logic                           rst_n,
  spnf_in_if.sink                        in_ch,
  spnf_out_if.source                     out_ch,
  input  logic                           cfg_we,
  input  logic [spnf_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [spnf_pkg::CFG_DAT_W-1:0] cfg_wdata
);

  logic                        offset_pos_r;
  logic [spnf_pkg::DIM_W-1:0]  columns_r;
  logic [spnf_pkg::DIM_W-1:0]  rows_r;
  spnf_pkg::dist_req_t         dist_req;
  logic                        near;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_pos_r <= 1'b1;
      columns_r    <= spnf_pkg::COLUMNS_RST;
      rows_r       <= spnf_pkg::ROWS_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        spnf_pkg::CFG_OFFSET_POS: offset_pos_r <= cfg_wdata[0];
        spnf_pkg::CFG_COLUMNS:    columns_r    <= cfg_wdata[spnf_pkg::DIM_W-1:0];
        spnf_pkg::CFG_ROWS:       rows_r       <= cfg_wdata[spnf_pkg::DIM_W-1:0];
        default: begin
          // drop writes to unmapped indexes
        end
      endcase
    end
  end

  spnf_scan u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .offset_pos (offset_pos_r),
    .columns    (columns_r),
    .rows       (rows_r),
    .dist_req   (dist_req),
    .near       (near)
  );

  spnf_dist u_dist (
    .req  (dist_req),
    .near (near)
  );

endmodule
